[hdl/eyedr_pkg.sv]
`default_nettype none
package eyedr_pkg;

    // Fixed field widths
    localparam int SCREEN_BITS = 11;
    localparam int EYE_BITS    = 9;
    localparam int POS_BITS    = 10;
    localparam int SIZE_BITS   = 11;

    // Padding added to each eye box
    localparam logic [POS_BITS-1:0] BOX_PAD = 10'd10;

    // Configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Display size after reset
    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 11'd320;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 11'd240;

    // Clipped union box of one eye; corners are exact whenever valid is set
    typedef struct packed {
        logic                   valid;
        logic                   clipped;
        logic [SCREEN_BITS-1:0] x0;
        logic [SCREEN_BITS-1:0] y0;
        logic [SCREEN_BITS-1:0] x1;
        logic [SCREEN_BITS-1:0] y1;
    } rect_t;

    // One result beat
    typedef struct packed {
        logic                 no_previous;
        logic                 main_valid;
        logic                 main_clipped;
        logic [POS_BITS-1:0]  main_x;
        logic [POS_BITS-1:0]  main_y;
        logic [SIZE_BITS-1:0] main_w;
        logic [SIZE_BITS-1:0] main_h;
        logic                 second_valid;
        logic [POS_BITS-1:0]  second_x;
        logic [POS_BITS-1:0]  second_y;
        logic [SIZE_BITS-1:0] second_w;
        logic [SIZE_BITS-1:0] second_h;
    } plan_t;

endpackage
`default_nettype wire

[hdl/eyedr_geom_if.sv]
`default_nettype none
interface eyedr_geom_if
#(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] left_center_x;
    logic [COORD_BITS-1:0] left_center_y;
    logic [COORD_BITS-1:0] right_center_x;
    logic [COORD_BITS-1:0] right_center_y;
    logic [8:0]            eye_width;
    logic [8:0]            eye_height;

    modport source
    (
        output valid, left_center_x, left_center_y, right_center_x, right_center_y,
               eye_width, eye_height,
        input  ready
    );

    modport sink
    (
        input  valid, left_center_x, left_center_y, right_center_x, right_center_y,
               eye_width, eye_height,
        output ready
    );
endinterface
`default_nettype wire

[hdl/eyedr_plan_if.sv]
`default_nettype none
interface eyedr_plan_if;
    logic        valid;
    logic        ready;
    logic        no_previous;
    logic        main_valid;
    logic        main_clipped;
    logic [9:0]  main_x;
    logic [9:0]  main_y;
    logic [10:0] main_w;
    logic [10:0] main_h;
    logic        second_valid;
    logic [9:0]  second_x;
    logic [9:0]  second_y;
    logic [10:0] second_w;
    logic [10:0] second_h;

    modport source
    (
        output valid, no_previous, main_valid, main_clipped, main_x, main_y, main_w,
               main_h, second_valid, second_x, second_y, second_w, second_h,
        input  ready
    );

    modport sink
    (
        input  valid, no_previous, main_valid, main_clipped, main_x, main_y, main_w,
               main_h, second_valid, second_x, second_y, second_w, second_h,
        output ready
    );
endinterface
`default_nettype wire

[hdl/eyedr_box_clip.sv]
`default_nettype none
module eyedr_box_clip
#(
    parameter int COORD_BITS = 10
)
(
    input  wire logic [COORD_BITS-1:0]            old_cx,
    input  wire logic [COORD_BITS-1:0]            old_cy,
    input  wire logic [eyedr_pkg::EYE_BITS-1:0]   old_ew,
    input  wire logic [eyedr_pkg::EYE_BITS-1:0]   old_eh,
    input  wire logic [COORD_BITS-1:0]            new_cx,
    input  wire logic [COORD_BITS-1:0]            new_cy,
    input  wire logic [eyedr_pkg::EYE_BITS-1:0]   new_ew,
    input  wire logic [eyedr_pkg::EYE_BITS-1:0]   new_eh,
    input  wire logic [eyedr_pkg::SCREEN_BITS-1:0] scr_w,
    input  wire logic [eyedr_pkg::SCREEN_BITS-1:0] scr_h,
    output eyedr_pkg::rect_t                      rect
);
    import eyedr_pkg::*;

    // Signed width that holds every padded edge without wrapping
    localparam int SW = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 2;

    logic [POS_BITS-1:0]  bw_old;
    logic [POS_BITS-1:0]  bh_old;
    logic [POS_BITS-1:0]  bw_new;
    logic [POS_BITS-1:0]  bh_new;
    logic signed [SW-1:0] ox0, oy0, ox1, oy1;
    logic signed [SW-1:0] nx0, ny0, nx1, ny1;
    logic signed [SW-1:0] ux0, uy0, ux1, uy1;
    logic signed [SW-1:0] cx0, cy0, cx1, cy1;
    logic signed [SW-1:0] sw_s, sh_s;

    // Padded box sizes
    assign bw_old = {1'b0, old_ew} + BOX_PAD;
    assign bh_old = {1'b0, old_eh} + BOX_PAD;
    assign bw_new = {1'b0, new_ew} + BOX_PAD;
    assign bh_new = {1'b0, new_eh} + BOX_PAD;

    // Box corners, centered by half the padded size
    assign ox0 = SW'(old_cx) - SW'(bw_old[POS_BITS-1:1]);
    assign oy0 = SW'(old_cy) - SW'(bh_old[POS_BITS-1:1]);
    assign ox1 = ox0 + SW'(bw_old);
    assign oy1 = oy0 + SW'(bh_old);
    assign nx0 = SW'(new_cx) - SW'(bw_new[POS_BITS-1:1]);
    assign ny0 = SW'(new_cy) - SW'(bh_new[POS_BITS-1:1]);
    assign nx1 = nx0 + SW'(bw_new);
    assign ny1 = ny0 + SW'(bh_new);

    // Bounding union of old and new boxes
    assign ux0 = (ox0 < nx0) ? ox0 : nx0;
    assign uy0 = (oy0 < ny0) ? oy0 : ny0;
    assign ux1 = (ox1 > nx1) ? ox1 : nx1;
    assign uy1 = (oy1 > ny1) ? oy1 : ny1;

    // Clip to the display
    assign sw_s = SW'(scr_w);
    assign sh_s = SW'(scr_h);
    assign cx0  = ux0[SW-1] ? '0 : ux0;
    assign cy0  = uy0[SW-1] ? '0 : uy0;
    assign cx1  = (ux1 > sw_s) ? sw_s : ux1;
    assign cy1  = (uy1 > sh_s) ? sh_s : uy1;

    assign rect.clipped = ux0[SW-1] || uy0[SW-1] || (ux1 > sw_s) || (uy1 > sh_s);
    assign rect.valid   = (cx1 > cx0) && (cy1 > cy0);
    assign rect.x0      = cx0[SCREEN_BITS-1:0];
    assign rect.y0      = cy0[SCREEN_BITS-1:0];
    assign rect.x1      = cx1[SCREEN_BITS-1:0];
    assign rect.y1      = cy1[SCREEN_BITS-1:0];

endmodule
`default_nettype wire

[hdl/eyedr_merge.sv]
`default_nettype none
module eyedr_merge
(
    input  wire logic             first,
    input  wire eyedr_pkg::rect_t left,
    input  wire eyedr_pkg::rect_t right,
    output eyedr_pkg::plan_t      plan
);
    import eyedr_pkg::*;

    logic                   touch;
    logic [SCREEN_BITS-1:0] mx0, my0, mx1, my1;
    logic [SCREEN_BITS-1:0] lw, lh, rw, rh;

    // Overlap or shared edge between two valid boxes
    assign touch = left.valid && right.valid &&
                   !((left.x1 < right.x0) || (right.x1 < left.x0) ||
                     (left.y1 < right.y0) || (right.y1 < left.y0));

    // Merged bounds
    assign mx0 = (left.x0 < right.x0) ? left.x0 : right.x0;
    assign my0 = (left.y0 < right.y0) ? left.y0 : right.y0;
    assign mx1 = (left.x1 > right.x1) ? left.x1 : right.x1;
    assign my1 = (left.y1 > right.y1) ? left.y1 : right.y1;

    // Per-eye sizes, zero when invalid
    assign lw = left.valid  ? (left.x1 - left.x0)   : '0;
    assign lh = left.valid  ? (left.y1 - left.y0)   : '0;
    assign rw = right.valid ? (right.x1 - right.x0) : '0;
    assign rh = right.valid ? (right.y1 - right.y0) : '0;

    // Pick merged or separate output
    always_comb
    begin
        plan.no_previous = first;
        if (touch)
        begin
            plan.main_valid   = 1'b1;
            plan.main_clipped = left.clipped || right.clipped;
            plan.main_x       = mx0[POS_BITS-1:0];
            plan.main_y       = my0[POS_BITS-1:0];
            plan.main_w       = mx1 - mx0;
            plan.main_h       = my1 - my0;
            plan.second_valid = 1'b0;
            plan.second_x     = '0;
            plan.second_y     = '0;
            plan.second_w     = '0;
            plan.second_h     = '0;
        end
        else
        begin
            plan.main_valid   = left.valid;
            plan.main_clipped = left.clipped;
            plan.main_x       = left.x0[POS_BITS-1:0];
            plan.main_y       = left.y0[POS_BITS-1:0];
            plan.main_w       = lw;
            plan.main_h       = lh;
            plan.second_valid = right.valid;
            plan.second_x     = right.x0[POS_BITS-1:0];
            plan.second_y     = right.y0[POS_BITS-1:0];
            plan.second_w     = rw;
            plan.second_h     = rh;
        end
    end

endmodule
`default_nettype wire

[hdl/eye_dirty_rect_planner_unit.sv]
// Channel   Dir  Beat
// geom      in   two eye centers and the shared eye size of one frame
// plan      out  primary and secondary dirty rectangles for that frame
// cfg       in   screen_width / screen_height writes
//
// One beat per cycle sustained while plan is ready; a taken beat goes through the input and result registers to plan.
// Input register -> box/union/clip per eye -> merge -> result register.
// Reset clears the previous-frame flag and restores a 320 x 240 display.
// A stall on plan holds the result register, then the input register, then geom.ready.
`default_nettype none
module eye_dirty_rect_planner_unit
#(
    parameter int COORD_BITS = 10
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    eyedr_geom_if.sink                              geom,
    eyedr_plan_if.source                            plan,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [eyedr_pkg::SCREEN_BITS-1:0]  cfg_data
);
    import eyedr_pkg::*;

    logic [SCREEN_BITS-1:0] scr_w_reg;
    logic [SCREEN_BITS-1:0] scr_h_reg;

    logic                  have_prev_reg;
    logic [COORD_BITS-1:0] old_lx_reg, old_ly_reg, old_rx_reg, old_ry_reg;
    logic [EYE_BITS-1:0]   old_ew_reg, old_eh_reg;

    logic                  s1_valid_reg;
    logic                  s1_first_reg;
    logic [COORD_BITS-1:0] s1_lx_reg, s1_ly_reg, s1_rx_reg, s1_ry_reg;
    logic [EYE_BITS-1:0]   s1_ew_reg, s1_eh_reg;
    logic [COORD_BITS-1:0] s1_olx_reg, s1_oly_reg, s1_orx_reg, s1_ory_reg;
    logic [EYE_BITS-1:0]   s1_oew_reg, s1_oeh_reg;

    logic  out_valid_reg;
    plan_t res_reg;
    plan_t res_next;

    rect_t left_box;
    rect_t right_box;
    logic  accept;
    logic  s2_load;

    // Handshake
    assign s2_load    = s1_valid_reg && (!out_valid_reg || plan.ready);
    assign geom.ready = !s1_valid_reg || s2_load;
    assign accept     = geom.valid && geom.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= SCREEN_WIDTH_RST;
            scr_h_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                CFG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                default:           scr_w_reg <= scr_w_reg;
            endcase
        end
    end

    // Track whether a previous frame exists
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            have_prev_reg <= 1'b1;
        end
    end

    // Remember this frame's geometry for the next one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_lx_reg <= geom.left_center_x;
            old_ly_reg <= geom.left_center_y;
            old_rx_reg <= geom.right_center_x;
            old_ry_reg <= geom.right_center_y;
            old_ew_reg <= geom.eye_width;
            old_eh_reg <= geom.eye_height;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (geom.ready)
        begin
            s1_valid_reg <= geom.valid;
        end
    end

    // Capture the beat with its previous frame; the first frame is its own previous
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg <= !have_prev_reg;
            s1_lx_reg    <= geom.left_center_x;
            s1_ly_reg    <= geom.left_center_y;
            s1_rx_reg    <= geom.right_center_x;
            s1_ry_reg    <= geom.right_center_y;
            s1_ew_reg    <= geom.eye_width;
            s1_eh_reg    <= geom.eye_height;
            s1_olx_reg   <= have_prev_reg ? old_lx_reg : geom.left_center_x;
            s1_oly_reg   <= have_prev_reg ? old_ly_reg : geom.left_center_y;
            s1_orx_reg   <= have_prev_reg ? old_rx_reg : geom.right_center_x;
            s1_ory_reg   <= have_prev_reg ? old_ry_reg : geom.right_center_y;
            s1_oew_reg   <= have_prev_reg ? old_ew_reg : geom.eye_width;
            s1_oeh_reg   <= have_prev_reg ? old_eh_reg : geom.eye_height;
        end
    end

    // Per-eye union and clip
    eyedr_box_clip #(.COORD_BITS(COORD_BITS)) u_left
    (
        .old_cx (s1_olx_reg),
        .old_cy (s1_oly_reg),
        .old_ew (s1_oew_reg),
        .old_eh (s1_oeh_reg),
        .new_cx (s1_lx_reg),
        .new_cy (s1_ly_reg),
        .new_ew (s1_ew_reg),
        .new_eh (s1_eh_reg),
        .scr_w  (scr_w_reg),
        .scr_h  (scr_h_reg),
        .rect   (left_box)
    );

    eyedr_box_clip #(.COORD_BITS(COORD_BITS)) u_right
    (
        .old_cx (s1_orx_reg),
        .old_cy (s1_ory_reg),
        .old_ew (s1_oew_reg),
        .old_eh (s1_oeh_reg),
        .new_cx (s1_rx_reg),
        .new_cy (s1_ry_reg),
        .new_ew (s1_ew_reg),
        .new_eh (s1_eh_reg),
        .scr_w  (scr_w_reg),
        .scr_h  (scr_h_reg),
        .rect   (right_box)
    );

    // Merge or keep apart
    eyedr_merge u_merge
    (
        .first (s1_first_reg),
        .left  (left_box),
        .right (right_box),
        .plan  (res_next)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || plan.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            res_reg <= res_next;
        end
    end

    // Drive the result beat
    assign plan.valid        = out_valid_reg;
    assign plan.no_previous  = res_reg.no_previous;
    assign plan.main_valid   = res_reg.main_valid;
    assign plan.main_clipped = res_reg.main_clipped;
    assign plan.main_x       = res_reg.main_x;
    assign plan.main_y       = res_reg.main_y;
    assign plan.main_w       = res_reg.main_w;
    assign plan.main_h       = res_reg.main_h;
    assign plan.second_valid = res_reg.second_valid;
    assign plan.second_x     = res_reg.second_x;
    assign plan.second_y     = res_reg.second_y;
    assign plan.second_w     = res_reg.second_w;
    assign plan.second_h     = res_reg.second_h;

endmodule
`default_nettype wire

[hdl/eyedr_checker.sv]
`default_nettype none
module eyedr_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        plan_valid,
    input wire logic        plan_ready,
    input wire logic        no_previous,
    input wire logic        main_valid,
    input wire logic [10:0] main_w,
    input wire logic [10:0] main_h,
    input wire logic        second_valid,
    input wire logic [10:0] second_w,
    input wire logic [10:0] second_h
);

    // Hold a stalled result beat
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid && !plan_ready |=> plan_valid)
        else $error("result beat dropped while stalled");

    // Empty primary box carries no size
    a_main_empty: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid && !main_valid |-> (main_w == 11'd0) && (main_h == 11'd0))
        else $error("invalid primary box has nonzero size");

    // Empty or merged secondary box carries no size
    a_second_empty: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid && !second_valid |-> (second_w == 11'd0) && (second_h == 11'd0))
        else $error("invalid secondary box has nonzero size");

    // A beat that directly follows a taken beat may not flag a missing previous frame
    a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid && plan_ready |=> !plan_valid || !no_previous)
        else $error("no_previous flagged on two beats in a row");

endmodule

bind eye_dirty_rect_planner_unit eyedr_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .plan_valid   (plan.valid),
    .plan_ready   (plan.ready),
    .no_previous  (plan.no_previous),
    .main_valid   (plan.main_valid),
    .main_w       (plan.main_w),
    .main_h       (plan.main_h),
    .second_valid (plan.second_valid),
    .second_w     (plan.second_w),
    .second_h     (plan.second_h)
);
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import eyedr_pkg::*;

    localparam int EYE_PAD     = int'(BOX_PAD);
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 116;

    // One geometry beat as seen on the bus
    typedef struct {
        logic [POS_BITS-1:0] left_x;
        logic [POS_BITS-1:0] left_y;
        logic [POS_BITS-1:0] right_x;
        logic [POS_BITS-1:0] right_y;
        logic [EYE_BITS-1:0] eye_w;
        logic [EYE_BITS-1:0] eye_h;
    } frame_geom_t;

    // Clipped box in wide signed terms
    typedef struct {
        bit valid;
        bit clipped;
        int x;
        int y;
        int w;
        int h;
    } dirty_box_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [SCREEN_BITS-1:0] cfg_data;

    eyedr_geom_if #(.COORD_BITS(POS_BITS)) geom_chan ();
    eyedr_plan_if                          plan_chan ();

    eye_dirty_rect_planner_unit #(.COORD_BITS(POS_BITS)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom_chan),
        .plan      (plan_chan),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: display size and previous frame
    int                  screen_w = int'(SCREEN_WIDTH_RST);
    int                  screen_h = int'(SCREEN_HEIGHT_RST);
    bit                  seen_frame;
    logic [POS_BITS-1:0] prev_left_x;
    logic [POS_BITS-1:0] prev_left_y;
    logic [POS_BITS-1:0] prev_right_x;
    logic [POS_BITS-1:0] prev_right_y;
    logic [EYE_BITS-1:0] prev_eye_w;
    logic [EYE_BITS-1:0] prev_eye_h;

    plan_t pending_plans[$];
    int    mismatches  = 0;
    int    idle_cycles = 0;
    bit    calm;

    // Random walk of a plausible face
    int walk_x;
    int walk_y;
    int walk_sep;
    int walk_dy;
    int walk_ew;
    int walk_eh;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_coord(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Union of old and new padded eye boxes, clipped to the display
    function automatic dirty_box_t eye_union(input int ocx, input int ocy, input int oew,
                                             input int oeh, input int ncx, input int ncy,
                                             input int new_ew, input int new_eh);
        dirty_box_t b;
        int ow, oh, ox, oy, nw, nh, nx, ny;
        int ux0, uy0, ux1, uy1, x0, y0, x1, y1;
        ow  = oew + EYE_PAD;
        oh  = oeh + EYE_PAD;
        ox  = ocx - ow / 2;
        oy  = ocy - oh / 2;
        nw  = new_ew + EYE_PAD;
        nh  = new_eh + EYE_PAD;
        nx  = ncx - nw / 2;
        ny  = ncy - nh / 2;
        ux0 = (ox < nx) ? ox : nx;
        uy0 = (oy < ny) ? oy : ny;
        ux1 = (ox + ow > nx + nw) ? ox + ow : nx + nw;
        uy1 = (oy + oh > ny + nh) ? oy + oh : ny + nh;
        x0  = (ux0 < 0) ? 0 : ux0;
        y0  = (uy0 < 0) ? 0 : uy0;
        x1  = (ux1 > screen_w) ? screen_w : ux1;
        y1  = (uy1 > screen_h) ? screen_h : uy1;
        b.clipped = (x0 != ux0) || (y0 != uy0) || (x1 != ux1) || (y1 != uy1);
        b.valid   = (x1 > x0) && (y1 > y0);
        b.x       = x0;
        b.y       = y0;
        b.w       = b.valid ? x1 - x0 : 0;
        b.h       = b.valid ? y1 - y0 : 0;
        return b;
    endfunction

    // Compute the plan of one frame and advance the previous-frame copy
    function automatic plan_t predict_plan(input frame_geom_t g);
        plan_t      p;
        dirty_box_t lb, rb, mb, sb;
        bit         first, touch;
        int         mx1, my1;
        first = !seen_frame;
        if (first)
        begin
            prev_left_x  = g.left_x;
            prev_left_y  = g.left_y;
            prev_right_x = g.right_x;
            prev_right_y = g.right_y;
            prev_eye_w   = g.eye_w;
            prev_eye_h   = g.eye_h;
        end
        lb = eye_union(int'(prev_left_x), int'(prev_left_y), int'(prev_eye_w),
                       int'(prev_eye_h), int'(g.left_x), int'(g.left_y),
                       int'(g.eye_w), int'(g.eye_h));
        rb = eye_union(int'(prev_right_x), int'(prev_right_y), int'(prev_eye_w),
                       int'(prev_eye_h), int'(g.right_x), int'(g.right_y),
                       int'(g.eye_w), int'(g.eye_h));
        touch = lb.valid && rb.valid &&
                !((lb.x + lb.w) < rb.x || (rb.x + rb.w) < lb.x ||
                  (lb.y + lb.h) < rb.y || (rb.y + rb.h) < lb.y);
        if (touch)
        begin
            // Merge into one box covering both eyes
            mx1        = (lb.x + lb.w > rb.x + rb.w) ? lb.x + lb.w : rb.x + rb.w;
            my1        = (lb.y + lb.h > rb.y + rb.h) ? lb.y + lb.h : rb.y + rb.h;
            mb.valid   = 1'b1;
            mb.clipped = lb.clipped || rb.clipped;
            mb.x       = (lb.x < rb.x) ? lb.x : rb.x;
            mb.y       = (lb.y < rb.y) ? lb.y : rb.y;
            mb.w       = mx1 - mb.x;
            mb.h       = my1 - mb.y;
            sb         = '{1'b0, 1'b0, 0, 0, 0, 0};
        end
        else
        begin
            mb = lb;
            sb = rb;
        end
        p.no_previous  = first;
        p.main_valid   = mb.valid;
        p.main_clipped = mb.clipped;
        p.main_x       = POS_BITS'(mb.x);
        p.main_y       = POS_BITS'(mb.y);
        p.main_w       = SIZE_BITS'(mb.w);
        p.main_h       = SIZE_BITS'(mb.h);
        p.second_valid = sb.valid;
        p.second_x     = POS_BITS'(sb.x);
        p.second_y     = POS_BITS'(sb.y);
        p.second_w     = SIZE_BITS'(sb.w);
        p.second_h     = SIZE_BITS'(sb.h);
        seen_frame   = 1'b1;
        prev_left_x  = g.left_x;
        prev_left_y  = g.left_y;
        prev_right_x = g.right_x;
        prev_right_y = g.right_y;
        prev_eye_w   = g.eye_w;
        prev_eye_h   = g.eye_h;
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [10:0] want,
                                        input logic [10:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endfunction

    // Predict on each geometry beat, then compare each plan beat
    always @(posedge clk)
    begin : plan_scoreboard
        frame_geom_t g;
        plan_t       want;
        plan_t       got;
        if (rst_n === 1'b1)
        begin
            if (geom_chan.valid === 1'b1 && geom_chan.ready === 1'b1)
            begin
                g = '{geom_chan.left_center_x, geom_chan.left_center_y,
                      geom_chan.right_center_x, geom_chan.right_center_y,
                      geom_chan.eye_width, geom_chan.eye_height};
                pending_plans.push_back(predict_plan(g));
            end
            if (plan_chan.valid === 1'b1 && plan_chan.ready === 1'b1)
            begin
                got = '{plan_chan.no_previous, plan_chan.main_valid, plan_chan.main_clipped,
                        plan_chan.main_x, plan_chan.main_y, plan_chan.main_w,
                        plan_chan.main_h, plan_chan.second_valid, plan_chan.second_x,
                        plan_chan.second_y, plan_chan.second_w, plan_chan.second_h};
                if (pending_plans.size() == 0)
                begin
                    $error("plan beat with no frame waiting");
                    mismatches++;
                end
                else
                begin
                    want = pending_plans.pop_front();
                    check_field("no_previous", 11'(want.no_previous), 11'(got.no_previous));
                    check_field("main_valid", 11'(want.main_valid), 11'(got.main_valid));
                    check_field("main_clipped", 11'(want.main_clipped),
                                11'(got.main_clipped));
                    check_field("main_x", 11'(want.main_x), 11'(got.main_x));
                    check_field("main_y", 11'(want.main_y), 11'(got.main_y));
                    check_field("main_w", want.main_w, got.main_w);
                    check_field("main_h", want.main_h, got.main_h);
                    check_field("second_valid", 11'(want.second_valid),
                                11'(got.second_valid));
                    check_field("second_x", 11'(want.second_x), 11'(got.second_x));
                    check_field("second_y", 11'(want.second_y), 11'(got.second_y));
                    check_field("second_w", want.second_w, got.second_w);
                    check_field("second_h", want.second_h, got.second_h);
                end
            end
        end
    end

    // Abort when neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((geom_chan.valid === 1'b1 && geom_chan.ready === 1'b1) ||
            (plan_chan.valid === 1'b1 && plan_chan.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stall the plan channel at random
    initial
    begin : plan_ready_drive
        int stall;
        plan_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                plan_chan.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            plan_chan.ready <= 1'b1;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
    end

    // Offer one frame after a random gap; return once it is taken
    task automatic send_frame(input int lx, input int ly, input int rx, input int ry,
                              input int ew, input int eh);
        int gap;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            geom_chan.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        geom_chan.valid          <= 1'b1;
        geom_chan.left_center_x  <= POS_BITS'(lx);
        geom_chan.left_center_y  <= POS_BITS'(ly);
        geom_chan.right_center_x <= POS_BITS'(rx);
        geom_chan.right_center_y <= POS_BITS'(ry);
        geom_chan.eye_width      <= EYE_BITS'(ew);
        geom_chan.eye_height     <= EYE_BITS'(eh);
        @(posedge clk);
        while (geom_chan.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Drop valid and hold until every plan is back, plus pipeline slack
    task automatic drain_plans();
        @(negedge clk);
        geom_chan.valid <= 1'b0;
        while (pending_plans.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write both display registers; block must be idle
    task automatic set_screen(input int w, input int h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= SCREEN_BITS'(w);
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= SCREEN_BITS'(h);
        @(negedge clk);
        cfg_we   <= 1'b0;
        screen_w = w & 11'h7FF;
        screen_h = h & 11'h7FF;
    endtask

    // Hand-picked frames on the reset display size
    task automatic test_reset_display();
        send_frame(100, 100, 200, 100, 40, 20);
        send_frame(100, 100, 200, 100, 40, 20);
        // Boxes that just touch, then a one-pixel gap
        send_frame(100, 100, 130, 100, 20, 20);
        send_frame(100, 100, 130, 100, 20, 20);
        send_frame(100, 100, 131, 100, 20, 20);
        send_frame(100, 100, 131, 100, 20, 20);
        // Clip at the top-left corner
        send_frame(0, 0, 0, 0, 0, 0);
        send_frame(0, 0, 0, 0, 0, 0);
        // Far off screen: nothing valid once the previous frame is off screen too
        send_frame(1023, 1023, 1023, 1023, 511, 511);
        send_frame(1023, 1023, 1023, 1023, 511, 511);
        send_frame(160, 120, 160, 120, 511, 511);
        send_frame(50, 50, 250, 50, 1, 1);
        send_frame(50, 230, 310, 5, 1, 0);
    endtask

    // Display sizes at and past the limits
    task automatic test_screen_extremes();
        drain_plans();
        set_screen(0, 0);
        send_frame(10, 10, 40, 40, 5, 5);
        send_frame(0, 0, 1023, 1023, 0, 0);
        drain_plans();
        set_screen(1, 1);
        send_frame(0, 0, 0, 0, 0, 0);
        send_frame(5, 0, 0, 5, 0, 0);
        drain_plans();
        set_screen(1024, 1024);
        send_frame(1023, 1023, 0, 0, 511, 0);
        send_frame(1018, 1018, 5, 5, 0, 511);
        drain_plans();
        set_screen(2047, 2047);
        send_frame(1023, 1023, 1023, 1023, 511, 511);
        send_frame(1023, 1023, 1023, 1023, 511, 511);
        drain_plans();
        set_screen(2047, 1);
        send_frame(600, 0, 900, 0, 300, 0);
    endtask

    // Pause the sender until every plan is back, then resume
    task automatic test_full_pause();
        repeat (10)
            send_frame($urandom_range(0, 300), $urandom_range(0, 220),
                       $urandom_range(0, 300), $urandom_range(0, 220),
                       $urandom_range(0, 60), $urandom_range(0, 60));
        drain_plans();
        repeat (10)
            send_frame($urandom_range(0, 300), $urandom_range(0, 220),
                       $urandom_range(0, 300), $urandom_range(0, 220),
                       $urandom_range(0, 60), $urandom_range(0, 60));
    endtask

    // Place the face somewhere new on the display
    task automatic restart_walk();
        walk_x   = $urandom_range(0, clamp_coord(screen_w, 1023));
        walk_y   = $urandom_range(0, clamp_coord(screen_h, 1023));
        walk_ew  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 80);
        walk_eh  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 80);
        walk_sep = $urandom_range(0, 2 * (walk_ew + EYE_PAD) + 8);
        walk_dy  = $urandom_range(0, 16) - 8;
    endtask

    // Mostly a drifting face, with jumps and raw noise mixed in
    task automatic test_random_frames();
        int roll;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_plans();
            unique case (phase % 4)
                0: set_screen($urandom_range(1, 1024), $urandom_range(1, 1024));
                1: set_screen(1024, $urandom_range(0, 16));
                2: set_screen($urandom_range(0, 16), $urandom_range(1025, 2047));
                default: set_screen($urandom_range(1025, 2047), $urandom_range(1, 1024));
            endcase
            calm = (phase == 0) || (phase == 5);
            restart_walk();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    send_frame($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 511), $urandom_range(0, 511));
                end
                else
                begin
                    if (roll < 16)
                        restart_walk();
                    walk_x = clamp_coord(walk_x + $urandom_range(0, 16) - 8, 1023);
                    walk_y = clamp_coord(walk_y + $urandom_range(0, 16) - 8, 1023);
                    if (roll < 25)
                        walk_sep = clamp_coord(walk_sep + $urandom_range(0, 8) - 4, 1023);
                    send_frame(walk_x, walk_y, clamp_coord(walk_x + walk_sep, 1023),
                               clamp_coord(walk_y + walk_dy, 1023), walk_ew, walk_eh);
                end
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = CFG_SCREEN_WIDTH;
        cfg_data                 = '0;
        geom_chan.valid          = 1'b0;
        geom_chan.left_center_x  = '0;
        geom_chan.left_center_y  = '0;
        geom_chan.right_center_x = '0;
        geom_chan.right_center_y = '0;
        geom_chan.eye_width      = '0;
        geom_chan.eye_height     = '0;
        calm                     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_display();
        test_screen_extremes();
        test_full_pause();
        test_random_frames();

        drain_plans();
        repeat (10) @(posedge clk);
        if (pending_plans.size() != 0)
            $error("%0d plans never arrived", pending_plans.size());
        if (mismatches == 0 && pending_plans.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
